/* hdl/mmh_pkg.sv */
package mmh_pkg;

  localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT  = 47;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  typedef enum logic [2:0] {
    OP_TOTAL,
    OP_WORD,
    OP_MIX_T,
    OP_H_XOR_T,
    OP_H_XOR_LOW,
    OP_MIX_H
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_H_INIT,
    WB_T,
    WB_H,
    WB_OUT
  } wb_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT_MUL,
    ST_INIT_WB,
    ST_W_MUL,
    ST_W_WB,
    ST_MIX_MUL,
    ST_MIX_WB,
    ST_H_MUL,
    ST_H_WB,
    ST_FIN_MUL,
    ST_FIN_WB
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_go;
    mul_op_t op;
    wb_t     wb;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic partial;
  } sts_t;

  function automatic logic [63:0] mix47(input logic [63:0] v);
    mix47 = v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

/* hdl/multiplicative_mix_hash_64_core.sv */
// 64-bit multiplicative mix hash (MurmurHash64A byte-string form) over a stream of
// little-endian 64-bit words. Mark the first word of a key with in_first_word (it
// restarts the hash from the seed and in_total_length) and the final word with
// in_last_word, which produces one out_hash_value transaction. Byte counts above 8
// count as 8; a key of zero bytes is one transaction with byte count 0. The seed
// must be written through cfg_we/cfg_wdata only while the core is idle; the core
// does not enforce this. One item is handled at a time, and every 64-bit multiply
// by the constant runs in a single shared multiplier (a MUL state registers the
// partial products, a WB state stores the result). An item needs N multiplies,
// N = (1 if first) + (3 full word, 1 partial, 0 none) + (1 if last). The result
// sits in an output register; a new item is taken while it waits, and the core
// only stalls at the end of a later key while the previous hash is still untaken.
module multiplicative_mix_hash_64_core
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [63:0] in_total_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);

  cmd_t cmd;
  sts_t sts;

  mmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mmh_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_first_word   (in_first_word),
    .in_last_word    (in_last_word),
    .in_total_length (in_total_length),
    .out_hash_value  (out_hash_value)
  );

endmodule

/* hdl/mmh_mul.sv */
module mmh_mul
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        mul_go,
  input  logic [63:0] mul_a,
  output logic [63:0] mul_res
);

  logic [63:0] pp_ll_r;
  logic [31:0] pp_lh_r;
  logic [31:0] pp_hl_r;
  logic [31:0] cross_sum;

  // low 64 bits of a * HASH_MUL from three 32x32 partial products
  always_ff @(posedge clk) begin
    if (mul_go) begin
      pp_ll_r <= {32'd0, mul_a[31:0]} * {32'd0, HASH_MUL[31:0]};
      pp_lh_r <= mul_a[31:0] * HASH_MUL[63:32];
      pp_hl_r <= mul_a[63:32] * HASH_MUL[31:0];
    end
  end

  assign cross_sum = pp_lh_r + pp_hl_r;
  assign mul_res   = pp_ll_r + {cross_sum, 32'd0};

endmodule

/* hdl/mmh_datapath.sv */
module mmh_datapath
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [63:0] in_total_length,
  output logic [63:0] out_hash_value
);

  logic [63:0] seed_r;
  logic [63:0] h_r;
  logic [63:0] t_r;
  logic [63:0] word_r;
  logic [63:0] total_r;
  logic [3:0]  cnt_r;
  logic        first_r;
  logic        last_r;
  logic [63:0] hash_r;
  logic [3:0]  cnt_sat;
  logic [63:0] low_word;
  logic [63:0] mul_a;
  logic [63:0] mul_res;

  assign cnt_sat = (in_byte_count > WORD_BYTES) ? WORD_BYTES : in_byte_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      h_r     <= '0;
      cnt_r   <= '0;
      first_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (cmd.load_in) begin
        cnt_r   <= cnt_sat;
        first_r <= in_first_word;
        last_r  <= in_last_word;
      end
      if (cmd.wb == WB_H_INIT) begin
        h_r <= seed_r ^ mul_res;
      end else if (cmd.wb == WB_H) begin
        h_r <= mul_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      word_r  <= in_data_word;
      total_r <= in_total_length;
    end
    if (cmd.wb == WB_T) begin
      t_r <= mul_res;
    end
    if (cmd.wb == WB_OUT) begin
      hash_r <= mix47(mul_res);
    end
  end

  // keep only the valid low bytes of a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      low_word[i*8 +: 8] = (4'(i) < cnt_r) ? word_r[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_TOTAL:     mul_a = total_r;
      OP_WORD:      mul_a = word_r;
      OP_MIX_T:     mul_a = mix47(t_r);
      OP_H_XOR_T:   mul_a = h_r ^ t_r;
      OP_H_XOR_LOW: mul_a = h_r ^ low_word;
      OP_MIX_H:     mul_a = mix47(h_r);
      default:      mul_a = total_r;
    endcase
  end

  mmh_mul u_mul (
    .clk     (clk),
    .mul_go  (cmd.mul_go),
    .mul_a   (mul_a),
    .mul_res (mul_res)
  );

  assign sts.first   = first_r;
  assign sts.last    = last_r;
  assign sts.full    = (cnt_r == WORD_BYTES);
  assign sts.partial = (cnt_r != 4'd0) && (cnt_r != WORD_BYTES);

  assign out_hash_value = hash_r;

endmodule

/* hdl/mmh_ctrl.sv */
module mmh_ctrl
  import mmh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  function automatic state_t data_step(input sts_t s);
    priority if (s.full) begin
      data_step = ST_W_MUL;
    end else if (s.partial) begin
      data_step = ST_H_MUL;
    end else if (s.last) begin
      data_step = ST_FIN_MUL;
    end else begin
      data_step = ST_IDLE;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.mul_go    = 1'b0;
    cmd.op        = OP_TOTAL;
    cmd.wb        = WB_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = sts.first ? ST_INIT_MUL : data_step(sts);
      end
      ST_INIT_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_TOTAL;
        state_nxt  = ST_INIT_WB;
      end
      ST_INIT_WB: begin
        cmd.wb    = WB_H_INIT;
        state_nxt = data_step(sts);
      end
      ST_W_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_WORD;
        state_nxt  = ST_W_WB;
      end
      ST_W_WB: begin
        cmd.wb    = WB_T;
        state_nxt = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_MIX_T;
        state_nxt  = ST_MIX_WB;
      end
      ST_MIX_WB: begin
        cmd.wb    = WB_T;
        state_nxt = ST_H_MUL;
      end
      ST_H_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = sts.full ? OP_H_XOR_T : OP_H_XOR_LOW;
        state_nxt  = ST_H_WB;
      end
      ST_H_WB: begin
        cmd.wb    = WB_H;
        state_nxt = sts.last ? ST_FIN_MUL : ST_IDLE;
      end
      ST_FIN_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_MIX_H;
        state_nxt  = ST_FIN_WB;
      end
      ST_FIN_WB: begin
        // wait here until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.wb        = WB_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
